// File: rtl/csma_pkg.sv
// ----------------------------------------------------------------------------
// csma_pkg
// Shared types and constants of the CSMA-CA link MAC.
// ----------------------------------------------------------------------------
package csma_pkg;

  localparam logic [1:0] REQ_RX_START = 2'd0;
  localparam logic [1:0] REQ_RX_TIMER = 2'd1;
  localparam logic [1:0] REQ_TX       = 2'd2;
  localparam logic [1:0] REQ_CSMA     = 2'd3;

  localparam logic [1:0] PHY_IDLE = 2'd0;
  localparam logic [1:0] PHY_RX   = 2'd1;
  localparam logic [1:0] PHY_RXC  = 2'd2;
  localparam logic [1:0] PHY_TX   = 2'd3;

  localparam logic [1:0] TMR_NONE = 2'd0;
  localparam logic [1:0] TMR_RX   = 2'd1;
  localparam logic [1:0] TMR_CSMA = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOO_LONG = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_GIVEUP   = 3'd3;
  localparam logic [2:0] ST_RX_LOST  = 3'd4;
  localparam logic [2:0] ST_RX_IGN   = 3'd5;

  localparam logic [1:0] CFG_OWN_ADDR = 2'd0;
  localparam logic [1:0] CFG_RATE     = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN  = 2'd2;
  localparam logic [1:0] CFG_QLIMIT   = 2'd3;

  localparam logic [15:0] BCAST_ADDR = 16'hffff;
  localparam int          DIV_W      = 26;

  typedef struct packed {
    logic        start;
    logic [25:0] dividend;
    logic [20:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [24:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_OUT  = 4'b0100,
    S_WAIT = 4'b1000
  } fsm_t;

endpackage

// File: rtl/csma_div.sv
// ----------------------------------------------------------------------------
// csma_div
// Restoring divider, one quotient bit per cycle, for the airtime.
// ----------------------------------------------------------------------------
module csma_div
  import csma_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [21:0]      rem_r, rem_nxt;
  logic [20:0]      dvs_r, dvs_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [21:0]      trial;
  logic [22:0]      diff;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[20:0], quo_r[DIV_W-1]};
    diff     = {1'b0, trial} - {2'b00, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 5'(DIV_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[22]) begin
        rem_nxt = diff[21:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[24:0];

endmodule

// File: rtl/csma_ca_link_mac_unit.sv
// ----------------------------------------------------------------------------
// csma_ca_link_mac_unit
// Link MAC with unslotted CSMA-CA transmit queue and one-packet receiver.
// ----------------------------------------------------------------------------
// One event word in, one result word out. Events that need an airtime
// (receive start, transmission start) run the bit-serial divider, one
// quotient bit per cycle over 26 bits, and pass through S_WAIT, S_DIV and
// S_OUT before the result word appears. All other events go from S_IDLE
// through S_OUT to the result word. One event is handled at a time; the
// result register holds its word until taken and the input stalls
// meanwhile.
module csma_ca_link_mac_unit
  import csma_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int MIN_EXPONENT = 3,
  parameter int MAX_EXPONENT = 5,
  parameter int MAX_BACKOFFS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pkt_len[11:0], pkt_dst[27:12], pkt_src[43:28], pkt_tag[51:44],
  // random_bits[56:52]
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  // timer_delay_us[24:0], deliver_valid[25], deliver_src[41:26],
  // deliver_tag[49:42], transmit_valid[50], transmit_tag[58:51],
  // event_status[61:59], phy_state_now[63:62], queue_count_now[68:64]
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser   // timer_action
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EXP_TOP = (MIN_EXPONENT > MAX_EXPONENT) ? MIN_EXPONENT : MAX_EXPONENT;
  localparam int EW = $clog2(EXP_TOP + 1);
  localparam int BW = (MAX_BACKOFFS > 0) ? $clog2(MAX_BACKOFFS + 1) : 1;

  logic [15:0] own_r;
  logic [19:0] rate_r;
  logic [11:0] maxlen_r;
  logic [4:0]  qlim_r;

  fsm_t        st_r, st_nxt;
  logic [1:0]  phy_r, phy_nxt;
  logic [15:0] rxsrc_r, rxsrc_nxt, rxdst_r, rxdst_nxt;
  logic [7:0]  rxtag_r, rxtag_nxt;
  logic [QW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [BW-1:0] bcnt_r, bcnt_nxt;
  logic [EW-1:0] bexp_r, bexp_nxt;

  logic [19:0] qmem [QUEUE_DEPTH];
  logic [19:0] qrd_r;
  logic        qwe;
  logic [QW-1:0] qwa;
  logic [CW:0] qsum;

  logic [1:0]  act_r, act_nxt;
  logic [24:0] dly_r, dly_nxt;
  logic        dv_r, dv_nxt, tv_r, tv_nxt;
  logic [15:0] dsrc_r, dsrc_nxt;
  logic [7:0]  dtag_r, dtag_nxt, ttag_r, ttag_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic        ovld_r, ovld_nxt;
  logic        div_src_r, div_src_nxt;
  logic [11:0] dlen_r, dlen_nxt;

  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [1:0]  req;
  logic [11:0] len;
  logic [15:0] dst, src;
  logic [7:0]  tag;
  logic [4:0]  rnd;
  logic        acc;
  logic [CW-1:0] lim;
  logic [EW:0] be_inc;
  logic [EW-1:0] be_up;
  logic [QW-1:0] head_inc;

  assign req = in_tuser;
  assign len = in_tdata[11:0];
  assign dst = in_tdata[27:12];
  assign src = in_tdata[43:28];
  assign tag = in_tdata[51:44];
  assign rnd = in_tdata[56:52];
  assign in_tready = (st_r == S_IDLE) && !ovld_r;
  assign acc = in_tvalid && in_tready;

  function automatic logic [24:0] backoff(input logic [4:0] r, input int be);
    logic [4:0] m;
    m = 5'((32'd1 << ((be > 5) ? 5 : be)) - 32'd1);
    return 25'(r & m) * 25'd320;
  endfunction

  assign lim = (32'(qlim_r) > QUEUE_DEPTH) ? CW'(QUEUE_DEPTH) : CW'(qlim_r);
  assign be_inc = {1'b0, bexp_r} + 1'b1;
  assign be_up  = (be_inc > (EW+1)'(MAX_EXPONENT)) ? EW'(MAX_EXPONENT) : be_inc[EW-1:0];
  assign head_inc = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(head_r + 1'b1);
  assign qsum = {1'b0, cnt_r} + (CW+1)'(head_r);

  always_comb begin
    st_nxt = st_r; phy_nxt = phy_r;
    rxsrc_nxt = rxsrc_r; rxdst_nxt = rxdst_r; rxtag_nxt = rxtag_r;
    head_nxt = head_r; cnt_nxt = cnt_r; bcnt_nxt = bcnt_r; bexp_nxt = bexp_r;
    act_nxt = act_r; dly_nxt = dly_r; dv_nxt = dv_r; dsrc_nxt = dsrc_r;
    dtag_nxt = dtag_r; tv_nxt = tv_r; ttag_nxt = ttag_r; stat_nxt = stat_r;
    ovld_nxt = ovld_r; div_src_nxt = div_src_r; dlen_nxt = dlen_r;
    qwe = 1'b0;
    qwa = (qsum >= (CW+1)'(QUEUE_DEPTH)) ? QW'(qsum - (CW+1)'(QUEUE_DEPTH))
                                          : QW'(qsum);
    dreq.start = 1'b0;
    dreq.dividend = 26'(dlen_r) * 26'd15625;
    dreq.divisor = {(rate_r == '0) ? 20'd1 : rate_r, 1'b0};
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    case (st_r)
      S_IDLE: if (acc) begin
        act_nxt = TMR_NONE; dly_nxt = '0; dv_nxt = 1'b0; dsrc_nxt = '0;
        dtag_nxt = '0; tv_nxt = 1'b0; ttag_nxt = '0; stat_nxt = ST_OK;
        st_nxt = S_OUT;
        case (req)
          REQ_RX_START: begin
            if (phy_r == PHY_TX) stat_nxt = ST_RX_IGN;
            else begin
              phy_nxt = (phy_r == PHY_IDLE) ? PHY_RX : PHY_RXC;
              rxsrc_nxt = src; rxdst_nxt = dst; rxtag_nxt = tag;
              act_nxt = TMR_RX; dlen_nxt = len; div_src_nxt = 1'b0;
              st_nxt = S_WAIT;
            end
          end
          REQ_RX_TIMER: begin
            if (phy_r == PHY_TX) stat_nxt = ST_RX_IGN;
            else begin
              if (phy_r == PHY_RX &&
                  (rxdst_r == own_r || rxdst_r == BCAST_ADDR)) begin
                dv_nxt = 1'b1; dsrc_nxt = rxsrc_r; dtag_nxt = rxtag_r;
              end else if (phy_r == PHY_RXC) stat_nxt = ST_RX_LOST;
              phy_nxt = PHY_IDLE;
            end
          end
          REQ_TX: begin
            if (len > maxlen_r) stat_nxt = ST_TOO_LONG;
            else if (cnt_r >= lim) stat_nxt = ST_FULL;
            else begin
              qwe = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
              bcnt_nxt = '0; bexp_nxt = EW'(MIN_EXPONENT);
              act_nxt = TMR_CSMA; dly_nxt = backoff(rnd, MIN_EXPONENT);
            end
          end
          default: begin
            if (cnt_r != '0) begin
              if (phy_r == PHY_IDLE) begin
                phy_nxt = PHY_TX; tv_nxt = 1'b1; act_nxt = TMR_CSMA;
                div_src_nxt = 1'b1; st_nxt = S_WAIT;
              end else if (phy_r == PHY_TX) begin
                head_nxt = head_inc; cnt_nxt = cnt_r - 1'b1; phy_nxt = PHY_IDLE;
                if (cnt_r != CW'(1)) begin
                  act_nxt = TMR_CSMA; dly_nxt = backoff(rnd, MIN_EXPONENT);
                  bcnt_nxt = '0; bexp_nxt = EW'(MIN_EXPONENT);
                end
              end else if (32'(bcnt_r) + 1 > MAX_BACKOFFS) begin
                head_nxt = head_inc; cnt_nxt = cnt_r - 1'b1;
                bcnt_nxt = '0; stat_nxt = ST_GIVEUP;
                if (cnt_r != CW'(1)) begin
                  act_nxt = TMR_CSMA; dly_nxt = backoff(rnd, MIN_EXPONENT);
                  bexp_nxt = EW'(MIN_EXPONENT);
                end
              end else begin
                bcnt_nxt = BW'(bcnt_r + 1'b1); bexp_nxt = be_up;
                act_nxt = TMR_CSMA; dly_nxt = backoff(rnd, int'(be_up));
              end
            end
          end
        endcase
      end
      S_WAIT: begin
        if (div_src_r) begin
          dlen_nxt = qrd_r[11:0]; ttag_nxt = qrd_r[19:12];
        end
        st_nxt = S_DIV;
      end
      S_DIV: begin
        if (drsp.done) begin
          dly_nxt = drsp.quotient; st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        ovld_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  logic start_r;
  always_ff @(posedge clk) begin
    if (!rst_n) start_r <= 1'b0;
    else start_r <= (st_r == S_WAIT);
  end

  div_req_t dreq_q;
  always_comb begin
    dreq_q = dreq;
    dreq_q.start = start_r;
  end

  csma_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq_q), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (qwe) qmem[qwa] <= {tag, len};
    qrd_r <= qmem[head_r];
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt; dly_r <= dly_nxt; dv_r <= dv_nxt; dsrc_r <= dsrc_nxt;
    dtag_r <= dtag_nxt; tv_r <= tv_nxt; ttag_r <= ttag_nxt; stat_r <= stat_nxt;
    div_src_r <= div_src_nxt; dlen_r <= dlen_nxt;
    if (!rst_n) begin
      own_r <= '0; rate_r <= 20'd250; maxlen_r <= 12'd127; qlim_r <= 5'd16;
      st_r <= S_IDLE; phy_r <= PHY_IDLE; head_r <= '0; cnt_r <= '0;
      bcnt_r <= '0; bexp_r <= EW'(MIN_EXPONENT); ovld_r <= 1'b0;
      rxsrc_r <= '0; rxdst_r <= '0; rxtag_r <= '0;
    end else begin
      st_r <= st_nxt; phy_r <= phy_nxt; head_r <= head_nxt; cnt_r <= cnt_nxt;
      bcnt_r <= bcnt_nxt; bexp_r <= bexp_nxt; ovld_r <= ovld_nxt;
      rxsrc_r <= rxsrc_nxt; rxdst_r <= rxdst_nxt; rxtag_r <= rxtag_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_ADDR: own_r <= cfg_wdata[15:0];
          CFG_RATE:     rate_r <= cfg_wdata;
          CFG_MAX_LEN:  maxlen_r <= cfg_wdata[11:0];
          CFG_QLIMIT:   qlim_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tuser  = act_r;
  assign out_tdata  = {3'b000, 5'(cnt_r), phy_r, stat_r, ttag_r, tv_r,
                       dtag_r, dsrc_r, dv_r, dly_r};

endmodule

// File: rtl/csma_chk.sv
// ----------------------------------------------------------------------------
// csma_chk
// Port-level checks of the CSMA-CA link MAC, bound to the top level.
// ----------------------------------------------------------------------------
module csma_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");

  a_act: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("bad timer action");

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[68:64] <= 5'd16)
    else $error("queue count out of range");

endmodule

bind csma_ca_link_mac_unit csma_chk u_csma_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for csma_ca_link_mac_unit: drives MAC events over the
// input stream under random valid gaps and ready stalls, predicts each result
// word from an internal MAC model and compares every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
  import csma_pkg::*;
();

  localparam int QDEPTH     = 16;
  localparam int EXP_MIN    = 3;
  localparam int EXP_MAX    = 5;
  localparam int BACKOFF_LIM = 4;
  localparam int SLOT_US    = 320;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [1:0]  action;
    logic [24:0] delay;
    logic        dv;
    logic [15:0] dsrc;
    logic [7:0]  dtag;
    logic        tv;
    logic [7:0]  ttag;
    logic [2:0]  status;
    logic [1:0]  phy;
    logic [4:0]  qcnt;
  } mac_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  mac_result_t expected_results[$];
  int          error_count = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  // predictor state
  logic [15:0] m_addr;
  logic [19:0] m_rate;
  logic [11:0] m_maxlen;
  logic [4:0]  m_qlim;
  logic [1:0]  m_phy;
  logic [15:0] m_rx_src, m_rx_dst;
  logic [7:0]  m_rx_tag;
  logic [11:0] m_len_store[QDEPTH];
  logic [7:0]  m_tag_store[QDEPTH];
  int          m_head, m_count, m_nb, m_be;

  csma_ca_link_mac_unit u_dut (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_tready <= calm || ($urandom_range(99) >= 34);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [24:0] airtime(logic [11:0] len);
    longint unsigned r;
    r = (m_rate == 0) ? 1 : m_rate;
    return 25'((longint'(len) * 15625) / (2 * r));
  endfunction

  function automatic logic [24:0] backoff(logic [4:0] rnd, int be);
    return 25'((rnd & ((1 << be) - 1)) * SLOT_US);
  endfunction

  task automatic predict_mac(logic [1:0] req, logic [11:0] len, logic [15:0] dst,
                             logic [15:0] src, logic [7:0] tag, logic [4:0] rnd);
    mac_result_t r;
    int lim;
    int slot;
    r = '{default: '0};
    case (req)
      REQ_RX_START: begin
        if (m_phy == PHY_TX) r.status = ST_RX_IGN;
        else begin
          m_phy = (m_phy == PHY_IDLE) ? PHY_RX : PHY_RXC;
          m_rx_src = src; m_rx_dst = dst; m_rx_tag = tag;
          r.action = TMR_RX; r.delay = airtime(len);
        end
      end
      REQ_RX_TIMER: begin
        if (m_phy == PHY_TX) r.status = ST_RX_IGN;
        else begin
          if (m_phy == PHY_RX && (m_rx_dst == m_addr || m_rx_dst == BCAST_ADDR)) begin
            r.dv = 1'b1; r.dsrc = m_rx_src; r.dtag = m_rx_tag;
          end else if (m_phy == PHY_RXC) r.status = ST_RX_LOST;
          m_phy = PHY_IDLE;
        end
      end
      REQ_TX: begin
        lim = (m_qlim > QDEPTH) ? QDEPTH : m_qlim;
        if (len > m_maxlen) r.status = ST_TOO_LONG;
        else if (m_count >= lim) r.status = ST_FULL;
        else begin
          slot = (m_head + m_count) % QDEPTH;
          m_len_store[slot] = len; m_tag_store[slot] = tag;
          m_count++;
          m_nb = 0; m_be = EXP_MIN;
          r.action = TMR_CSMA; r.delay = backoff(rnd, m_be);
        end
      end
      default: begin
        if (m_count != 0) begin
          if (m_phy == PHY_IDLE) begin
            m_phy = PHY_TX;
            r.tv = 1'b1; r.ttag = m_tag_store[m_head];
            r.action = TMR_CSMA; r.delay = airtime(m_len_store[m_head]);
          end else if (m_phy == PHY_TX) begin
            m_head = (m_head + 1) % QDEPTH; m_count--;
            m_phy = PHY_IDLE;
            if (m_count != 0) begin
              m_nb = 0; m_be = EXP_MIN;
              r.action = TMR_CSMA; r.delay = backoff(rnd, m_be);
            end
          end else if (m_nb + 1 > BACKOFF_LIM) begin
            m_head = (m_head + 1) % QDEPTH; m_count--;
            m_nb = 0;
            r.status = ST_GIVEUP;
            if (m_count != 0) begin
              m_be = EXP_MIN;
              r.action = TMR_CSMA; r.delay = backoff(rnd, m_be);
            end
          end else begin
            m_nb++;
            m_be = (m_be + 1 > EXP_MAX) ? EXP_MAX : m_be + 1;
            r.action = TMR_CSMA; r.delay = backoff(rnd, m_be);
          end
        end
      end
    endcase
    r.phy = m_phy;
    r.qcnt = 5'(m_count);
    expected_results = {expected_results, r};
  endtask

  // called at a rising edge; returns at the edge that accepts the word
  task automatic send_word(logic [1:0] req, logic [11:0] len, logic [15:0] dst,
                           logic [15:0] src, logic [7:0] tag, logic [4:0] rnd);
    while (!calm && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {7'b0, rnd, tag, src, dst, len};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    predict_mac(req, len, dst, src, tag, rnd);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_OWN_ADDR: m_addr = val[15:0];
      CFG_RATE:     m_rate = val;
      CFG_MAX_LEN:  m_maxlen = val[11:0];
      default:      m_qlim = val[4:0];
    endcase
  endtask

  always @(negedge clk) begin
    mac_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word");
        error_count++;
      end else begin
        e = expected_results[0];
        expected_results.delete(0);
        if (out_tuser !== e.action) begin
          $error("timer_action exp %0d got %0d", e.action, out_tuser); error_count++;
        end
        if (out_tdata[24:0] !== e.delay) begin
          $error("timer_delay_us exp %0d got %0d", e.delay, out_tdata[24:0]); error_count++;
        end
        if (out_tdata[25] !== e.dv) begin
          $error("deliver_valid exp %0d got %0d", e.dv, out_tdata[25]); error_count++;
        end
        if (out_tdata[41:26] !== e.dsrc) begin
          $error("deliver_src exp %h got %h", e.dsrc, out_tdata[41:26]); error_count++;
        end
        if (out_tdata[49:42] !== e.dtag) begin
          $error("deliver_tag exp %h got %h", e.dtag, out_tdata[49:42]); error_count++;
        end
        if (out_tdata[50] !== e.tv) begin
          $error("transmit_valid exp %0d got %0d", e.tv, out_tdata[50]); error_count++;
        end
        if (out_tdata[58:51] !== e.ttag) begin
          $error("transmit_tag exp %h got %h", e.ttag, out_tdata[58:51]); error_count++;
        end
        if (out_tdata[61:59] !== e.status) begin
          $error("event_status exp %0d got %0d", e.status, out_tdata[61:59]); error_count++;
        end
        if (out_tdata[63:62] !== e.phy) begin
          $error("phy_state_now exp %0d got %0d", e.phy, out_tdata[63:62]); error_count++;
        end
        if (out_tdata[68:64] !== e.qcnt) begin
          $error("queue_count_now exp %0d got %0d", e.qcnt, out_tdata[68:64]); error_count++;
        end
      end
    end
  end

  task automatic test_receive_paths();
    write_reg(CFG_OWN_ADDR, 20'h1234);
    send_word(REQ_RX_TIMER, 12'd0, 16'h0, 16'h0, 8'h00, 5'd0);
    send_word(REQ_RX_START, 12'd0, 16'h1234, 16'hffff, 8'hff, 5'd31);
    send_word(REQ_RX_TIMER, 12'd0, 16'h0, 16'h0, 8'h00, 5'd0);
    send_word(REQ_RX_START, 12'd4095, 16'hffff, 16'h0001, 8'h01, 5'd0);
    send_word(REQ_RX_TIMER, 12'd0, 16'h0, 16'h0, 8'h00, 5'd0);
    send_word(REQ_RX_START, 12'd50, 16'h5555, 16'h0002, 8'h02, 5'd0);
    send_word(REQ_RX_TIMER, 12'd0, 16'h0, 16'h0, 8'h00, 5'd0);
    send_word(REQ_RX_START, 12'd10, 16'h1234, 16'h0003, 8'h03, 5'd0);
    send_word(REQ_RX_START, 12'd20, 16'h1234, 16'h0004, 8'h04, 5'd0);
    send_word(REQ_RX_TIMER, 12'd0, 16'h0, 16'h0, 8'h00, 5'd0);
  endtask

  task automatic test_transmit_paths();
    send_word(REQ_CSMA, 12'd0, 16'h0, 16'h0, 8'h00, 5'd7);
    send_word(REQ_TX, 12'd128, 16'h0, 16'h0, 8'hee, 5'd0);
    send_word(REQ_TX, 12'd127, 16'h0, 16'h0, 8'haa, 5'd31);
    send_word(REQ_CSMA, 12'd0, 16'h0, 16'h0, 8'h00, 5'd0);
    send_word(REQ_RX_START, 12'd9, 16'h0, 16'h0, 8'h11, 5'd0);
    send_word(REQ_RX_TIMER, 12'd0, 16'h0, 16'h0, 8'h00, 5'd0);
    send_word(REQ_TX, 12'd0, 16'h0, 16'h0, 8'hbb, 5'd21);
    send_word(REQ_CSMA, 12'd0, 16'h0, 16'h0, 8'h00, 5'd13);
    send_word(REQ_RX_START, 12'd4, 16'h0, 16'h0, 8'h22, 5'd0);
    repeat (5) send_word(REQ_CSMA, 12'd0, 16'h0, 16'h0, 8'h00, 5'd31);
    send_word(REQ_RX_TIMER, 12'd0, 16'h0, 16'h0, 8'h00, 5'd0);
    drain();
    write_reg(CFG_QLIMIT, 20'd0);
    send_word(REQ_TX, 12'd1, 16'h0, 16'h0, 8'h33, 5'd0);
    drain();
    write_reg(CFG_QLIMIT, 20'd1);
    send_word(REQ_TX, 12'd1, 16'h0, 16'h0, 8'h44, 5'd0);
    send_word(REQ_TX, 12'd1, 16'h0, 16'h0, 8'h55, 5'd0);
  endtask

  task automatic test_random_traffic(int n);
    logic [1:0]  req;
    logic [11:0] len;
    logic [15:0] dst;
    int          pick;
    repeat (n) begin
      pick = $urandom_range(99);
      req = (pick < 25) ? REQ_RX_START : (pick < 45) ? REQ_RX_TIMER :
            (pick < 70) ? REQ_TX : REQ_CSMA;
      len = ($urandom_range(9) == 0) ? 12'($urandom) :
            12'($urandom_range(m_maxlen == 0 ? 0 : m_maxlen));
      pick = $urandom_range(3);
      dst = (pick == 0) ? m_addr : (pick == 1) ? BCAST_ADDR : 16'($urandom);
      send_word(req, len, dst, 16'($urandom), 8'($urandom), 5'($urandom));
    end
  endtask

  task automatic test_config_sweep();
    drain();
    write_reg(CFG_RATE, 20'd0);
    write_reg(CFG_MAX_LEN, 20'd4095);
    write_reg(CFG_QLIMIT, 20'd31);
    write_reg(CFG_OWN_ADDR, 20'hffff);
    test_random_traffic(200);
    drain();
    write_reg(CFG_RATE, 20'hfffff);
    write_reg(CFG_MAX_LEN, 20'd0);
    write_reg(CFG_QLIMIT, 20'd16);
    write_reg(CFG_OWN_ADDR, 20'h0000);
    test_random_traffic(150);
    drain();
    write_reg(CFG_RATE, 20'd1);
    write_reg(CFG_MAX_LEN, 20'd200);
    write_reg(CFG_QLIMIT, 20'd4);
    calm = 1'b1;
    test_random_traffic(200);
    calm = 1'b0;
    drain();
    write_reg(CFG_RATE, 20'($urandom));
    write_reg(CFG_MAX_LEN, 20'($urandom_range(4095)));
    write_reg(CFG_QLIMIT, 20'($urandom_range(31)));
    write_reg(CFG_OWN_ADDR, 20'($urandom_range(65535)));
    test_random_traffic(250);
    drain();
    write_reg(CFG_RATE, 20'd250);
    write_reg(CFG_MAX_LEN, 20'd127);
    write_reg(CFG_QLIMIT, 20'd16);
    test_random_traffic(200);
  endtask

  initial begin
    m_addr = 16'h0; m_rate = 20'd250; m_maxlen = 12'd127; m_qlim = 5'd16;
    m_phy = PHY_IDLE; m_rx_src = '0; m_rx_dst = '0; m_rx_tag = '0;
    m_head = 0; m_count = 0; m_nb = 0; m_be = EXP_MIN;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_receive_paths();
    test_transmit_paths();
    test_config_sweep();
    drain();
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
